// ----- hw/rtl/rth_pkg.sv -----
package rth_pkg;

  // Hue arithmetic constants.
  localparam logic [7:0] HUE_SCALE    = 8'd43;
  localparam logic [7:0] OFFSET_RED   = 8'd0;
  localparam logic [7:0] OFFSET_GREEN = 8'd85;
  localparam logic [7:0] OFFSET_BLUE  = 8'd171;

  // Number of quotient bits produced by the divider pipeline.
  localparam int DIV_STEPS = 8;

  // Which channel is the largest.
  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  // One input word.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // One output word.
  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  // Front stage: channel ordering and the hue difference.
  typedef struct packed {
    logic       valid;
    logic [1:0] sel;
    logic       neg;
    logic [7:0] hi;
    logic [7:0] delta;
    logic [7:0] absdiff;
  } rth_front_t;

  // One stage of the two parallel restoring dividers.
  typedef struct packed {
    logic       valid;
    logic [1:0] sel;
    logic       neg;
    logic       grey;
    logic [7:0] hi;
    logic [7:0] delta;
    logic [7:0] sat_rem;
    logic [7:0] sat_num;
    logic [7:0] sat_q;
    logic [7:0] hue_rem;
    logic [7:0] hue_num;
    logic [7:0] hue_q;
  } rth_div_t;

endpackage

// ----- hw/rtl/rgb_to_hsv_8bit.sv -----
// Channel  Valid        Ready        Word
// -------  -----------  -----------  ----------------------------------
// input    pixel_valid  pixel_ready  pixel  (red, green, blue)
// output   hsv_valid    hsv_ready    hsv    (hue, saturation, brightness)
//
// A word accepted at the input reaches hsv through one stage for the channel
// ordering, one for the products, eight for the shared-step restoring dividers
// (one quotient bit per stage) and the output register.
// One word is accepted every cycle while the output register is empty or taken.
// The whole pipeline stalls together when the output register holds a word that
// is not taken, so nothing is lost or repeated. Reset clears only the valid bits.
module rgb_to_hsv_8bit
  import rth_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_ready,
  input  pixel_t pixel,
  output logic   hsv_valid,
  input  logic   hsv_ready,
  output hsv_t   hsv
);

  logic       en;
  rth_front_t front;
  rth_front_t front_next;
  rth_div_t   div [DIV_STEPS+1];
  rth_div_t   div_first;
  hsv_t       hsv_next;

  // One restoring step of both divisions.
  function automatic rth_div_t div_step(rth_div_t s);
    rth_div_t   o;
    logic [8:0] ts;
    logic [8:0] th;
    logic       qs;
    logic       qh;
    o  = s;
    ts = {s.sat_rem, s.sat_num[7]};
    th = {s.hue_rem, s.hue_num[7]};
    qs = (ts >= {1'b0, s.hi});
    qh = (th >= {1'b0, s.delta});
    o.sat_rem = qs ? 8'(ts - {1'b0, s.hi}) : ts[7:0];
    o.hue_rem = qh ? 8'(th - {1'b0, s.delta}) : th[7:0];
    o.sat_num = {s.sat_num[6:0], 1'b0};
    o.hue_num = {s.hue_num[6:0], 1'b0};
    o.sat_q   = {s.sat_q[6:0], qs};
    o.hue_q   = {s.hue_q[6:0], qh};
    return o;
  endfunction

  // The pipeline moves as one unless the output word is waiting.
  assign en          = !hsv_valid || hsv_ready;
  assign pixel_ready = en;

  // Find the largest channel, the spread and the signed hue difference.
  always_comb begin
    logic [7:0] lo;
    logic [8:0] diff;
    front_next       = '0;
    front_next.valid = pixel_valid;
    if (pixel.red >= pixel.green && pixel.red >= pixel.blue) begin
      front_next.sel = SEL_RED;
      front_next.hi  = pixel.red;
      diff           = {1'b0, pixel.green} - {1'b0, pixel.blue};
    end else if (pixel.green >= pixel.blue) begin
      front_next.sel = SEL_GREEN;
      front_next.hi  = pixel.green;
      diff           = {1'b0, pixel.blue} - {1'b0, pixel.red};
    end else begin
      front_next.sel = SEL_BLUE;
      front_next.hi  = pixel.blue;
      diff           = {1'b0, pixel.red} - {1'b0, pixel.green};
    end
    lo = pixel.red;
    if (pixel.green < lo) begin
      lo = pixel.green;
    end
    if (pixel.blue < lo) begin
      lo = pixel.blue;
    end
    front_next.delta   = front_next.hi - lo;
    front_next.neg     = diff[8];
    front_next.absdiff = diff[8] ? 8'(-diff) : diff[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid <= 1'b0;
    end else if (en) begin
      front <= front_next;
    end
  end

  // Form the dividends: delta * 255 and 43 * |difference|.
  always_comb begin
    logic [15:0] nsat;
    logic [15:0] nhue;
    nsat = {front.delta, 8'd0} - {8'd0, front.delta};
    nhue = {8'd0, front.absdiff} * {8'd0, HUE_SCALE};
    div_first         = '0;
    div_first.valid   = front.valid;
    div_first.sel     = front.sel;
    div_first.neg     = front.neg;
    div_first.grey    = (front.delta == 8'd0);
    div_first.hi      = front.hi;
    div_first.delta   = front.delta;
    div_first.sat_rem = nsat[15:8];
    div_first.sat_num = nsat[7:0];
    div_first.hue_rem = nhue[15:8];
    div_first.hue_num = nhue[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div[0].valid <= 1'b0;
    end else if (en) begin
      div[0] <= div_first;
    end
  end

  // Divider stages, one quotient bit each. Both quotients fit in eight bits.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        div[k+1].valid <= 1'b0;
      end else if (en) begin
        div[k+1] <= div_step(div[k]);
      end
    end
  end

  // Apply sign and offset to the hue; grey and black give zero hue and saturation.
  always_comb begin
    logic [7:0] offset;
    logic [7:0] term;
    case (div[DIV_STEPS].sel)
      SEL_GREEN: offset = OFFSET_GREEN;
      SEL_BLUE:  offset = OFFSET_BLUE;
      default:   offset = OFFSET_RED;
    endcase
    term = div[DIV_STEPS].neg ? 8'(-div[DIV_STEPS].hue_q) : div[DIV_STEPS].hue_q;
    hsv_next.brightness = div[DIV_STEPS].hi;
    if (div[DIV_STEPS].grey) begin
      hsv_next.hue        = 8'd0;
      hsv_next.saturation = 8'd0;
    end else begin
      hsv_next.hue        = offset + term;
      hsv_next.saturation = div[DIV_STEPS].sat_q;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hsv_valid <= 1'b0;
    end else if (en) begin
      hsv_valid <= div[DIV_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hsv <= hsv_next;
    end
  end

endmodule

// ----- tb/rgb_to_hsv_8bit_checker.sv -----
module rgb_to_hsv_8bit_checker
  import rth_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  input  logic   pixel_ready,
  input  pixel_t pixel,
  input  logic   hsv_valid,
  input  logic   hsv_ready,
  input  hsv_t   hsv,
  output int     mismatch_count,
  output int     hsv_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Converted words still owed by the block, oldest first.
  hsv_t hsv_expected[$];

  // Works out the HSV word for one pixel, with integer arithmetic throughout.
  function automatic hsv_t predict_hsv(input pixel_t px);
    int   r;
    int   g;
    int   b;
    int   top;
    int   bottom;
    int   delta;
    int   diff;
    int   offset;
    int   scale;
    hsv_t res;
    r      = px.red;
    g      = px.green;
    b      = px.blue;
    scale  = HUE_SCALE;
    top    = (r > g) ? r : g;
    top    = (top > b) ? top : b;
    bottom = (r < g) ? r : g;
    bottom = (bottom < b) ? bottom : b;
    delta  = top - bottom;
    res.hue        = 8'd0;
    res.saturation = 8'd0;
    res.brightness = 8'(top);
    // Black leaves hue and saturation at zero; grey leaves hue at zero.
    if (top != 0) begin
      res.saturation = 8'((delta * 255) / top);
      if (delta != 0) begin
        // Ties go to red first, then to green.
        if (top == r) begin
          diff   = g - b;
          offset = OFFSET_RED;
        end else if (top == g) begin
          diff   = b - r;
          offset = OFFSET_GREEN;
        end else begin
          diff   = r - g;
          offset = OFFSET_BLUE;
        end
        // Division truncates toward zero and the sum wraps round the circle.
        res.hue = 8'(offset + (scale * diff) / delta);
      end
    end
    return res;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  initial begin
    mismatch_count  = 0;
    hsv_outstanding = 0;
  end

  // Compare each word taken from the output, then record each word accepted at the input.
  always @(posedge clk) begin
    hsv_t want;
    if (!rst) begin
      if (hsv_valid && hsv_ready) begin
        if (hsv_expected.size() == 0) begin
          report_mismatch("unexpected word, hue", 0, hsv.hue);
        end else begin
          want = hsv_expected.pop_front();
          if (hsv.hue != want.hue) begin
            report_mismatch("hue", want.hue, hsv.hue);
          end
          if (hsv.saturation != want.saturation) begin
            report_mismatch("saturation", want.saturation, hsv.saturation);
          end
          if (hsv.brightness != want.brightness) begin
            report_mismatch("brightness", want.brightness, hsv.brightness);
          end
        end
      end
      if (pixel_valid && pixel_ready) begin
        hsv_expected.push_back(predict_hsv(pixel));
      end
      hsv_outstanding = hsv_expected.size();
    end
  end

endmodule

// ----- tb/rgb_to_hsv_8bit_tb.sv -----
module rgb_to_hsv_8bit_tb
  import rth_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_LIMIT = 40;
  localparam int N_DIRECTED   = 22;

  // Corners: black, white, greys, primaries, ties, hue wrap and saturation extremes.
  localparam logic [23:0] DIRECTED_PIXELS [N_DIRECTED] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000, 24'h00FF00,
    24'h0000FF, 24'hFF00FF, 24'hFF0001, 24'hFF0080, 24'hC8C80A, 24'h0AC8C8,
    24'h64C832, 24'h3264C8, 24'hC864FA, 24'h010000, 24'hFFFEFE, 24'h000100,
    24'hFEFF00, 24'hAA55AA, 24'h55AA55, 24'h7F80FF
  };

  logic   clk;
  logic   rst;
  logic   pixel_valid;
  logic   pixel_ready;
  pixel_t pixel;
  logic   hsv_valid;
  logic   hsv_ready;
  hsv_t   hsv;

  int mismatch_count;
  int hsv_outstanding;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_left;

  rgb_to_hsv_8bit i_dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .hsv_valid   (hsv_valid),
    .hsv_ready   (hsv_ready),
    .hsv         (hsv)
  );

  rgb_to_hsv_8bit_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .pixel_valid     (pixel_valid),
    .pixel_ready     (pixel_ready),
    .pixel           (pixel),
    .hsv_valid       (hsv_valid),
    .hsv_ready       (hsv_ready),
    .hsv             (hsv),
    .mismatch_count  (mismatch_count),
    .hsv_outstanding (hsv_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Guard against a hung handshake.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output side: random back-pressure, or a long hold-off when one is asked for.
  initial begin
    hsv_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        hsv_ready <= 1'b0;
      end else if (hold_off_left > 0) begin
        hsv_ready <= 1'b0;
        hold_off_left--;
      end else begin
        hsv_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one word, with random gaps ahead of it, and returns once it is accepted.
  task automatic send_pixel(input pixel_t word_in);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= word_in;
    do @(posedge clk); while (!pixel_ready);
  endtask

  // Stops offering and waits for every owed word to come out.
  task automatic wait_drained();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (hsv_outstanding != 0) @(negedge clk);
  endtask

  // Random pixel, weighted towards greys, ties, extremes and near-greys.
  function automatic pixel_t random_pixel();
    pixel_t px;
    logic [7:0] v;
    int k;
    px = pixel_t'(24'($urandom_range(24'hFFFFFF)));
    v  = 8'($urandom_range(255));
    k  = $urandom_range(2);
    case ($urandom_range(9))
      4: begin
        px = '{v, v, v};
      end
      5: begin
        if (k == 0) px.green = px.red;
        else if (k == 1) px.blue = px.green;
        else px.blue = px.red;
      end
      6: begin
        if ($urandom_range(1) == 1) px.red = {8{px.red[0]}};
        if ($urandom_range(1) == 1) px.green = {8{px.green[0]}};
        if ($urandom_range(1) == 1) px.blue = {8{px.blue[0]}};
      end
      7: begin
        px.red   = (v > 8'd252) ? v - 8'($urandom_range(3)) : v + 8'($urandom_range(3));
        px.green = (v > 8'd252) ? v - 8'($urandom_range(3)) : v + 8'($urandom_range(3));
        px.blue  = v;
      end
      8: begin
        if (k == 0) px.red = 8'd0;
        else if (k == 1) px.green = 8'd0;
        else px.blue = 8'd0;
      end
      9: begin
        if (k == 0) px.red = 8'hFF;
        else if (k == 1) px.green = 8'hFF;
        else px.blue = 8'hFF;
      end
      default: begin
      end
    endcase
    return px;
  endfunction

  // Stimulus and verdict.
  initial begin
    rst           = 1'b1;
    pixel_valid   = 1'b0;
    pixel         = '0;
    send_idle_pct = 31;
    recv_idle_pct = 53;
    hold_off_left = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners.
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_pixel(pixel_t'(DIRECTED_PIXELS[i]));
    end
    wait_drained();

    // Sender idles less than the receiver; a long hold-off fills the pipeline.
    for (int i = 0; i < 280; i++) begin
      send_pixel(random_pixel());
      if (i == 40) begin
        hold_off_left = 60;
      end
    end
    wait_drained();

    // The other way round.
    send_idle_pct = 53;
    recv_idle_pct = 31;
    for (int i = 0; i < 280; i++) begin
      send_pixel(random_pixel());
    end
    wait_drained();

    // Neither side idles.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 290; i++) begin
      send_pixel(random_pixel());
    end
    wait_drained();

    repeat (SETTLE_LIMIT) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/rth_pkg.sv
hw/rtl/rgb_to_hsv_8bit.sv
tb/rgb_to_hsv_8bit_checker.sv
tb/rgb_to_hsv_8bit_tb.sv
